// ===== rtl/core/quaternion_normalizer_defines.svh =====
// assertion helpers for the quaternion normaliser checker
`ifndef QUATERNION_NORMALIZER_DEFINES_SVH
`define QUATERNION_NORMALIZER_DEFINES_SVH

// same-cycle implication, masked while in reset
`define QN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define QN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset too
`define QN_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/qn_pkg.sv =====
package qn_pkg;

    localparam int QN_FRAC_BITS = 14;
    localparam int COMP_W       = 16;
    localparam int SQ_W         = 31;
    localparam int SUM_W        = 33;
    localparam int ROOT_W       = 17;
    localparam int LANES        = 4;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [LANES-1:0] quad_t;

endpackage

// ===== rtl/core/quaternion_normalizer.sv =====
// channel  | ports       | word layout
// input    | s_t*        | tdata: comp_w, comp_x, comp_y, comp_z (16 bits each, lsb first)
// output   | m_t*        | tdata: unit_w, unit_x, unit_y, unit_z; tuser: zero_length
//
// one word per cycle sustained while m_tready holds high; stages are the
// squaring lanes, sum, 17 root steps, one quotient bit per divider stage
// in four lanes, and the output register.
// aresetn clears only the stage valid bits; payload is not reset.
// each stage holds only when it is full and the one after it holds, so
// bubbles close up and input is taken while a result waits on m_tready.
module quaternion_normalizer
    import qn_pkg::*;
#(
    parameter int FRAC_BITS = QN_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [4*COMP_W-1:0]   s_tdata,   // comp_w, comp_x, comp_y, comp_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [4*COMP_W-1:0]   m_tdata,   // unit_w, unit_x, unit_y, unit_z
    output logic [0:0]            m_tuser    // zero_length
);

    localparam int QW       = FRAC_BITS + 1;
    localparam int SQRT_OFS = 2;
    localparam int DIV_OFS  = SQRT_OFS + ROOT_W;
    localparam int NS       = DIV_OFS + QW + 1;
    localparam logic [31:0] POS_LIMIT = 32'd32767;
    localparam logic [31:0] NEG_LIMIT = 32'd32768;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;

    always_comb begin
        ld[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = ld[0];

    // squaring lanes
    quad_t           quad_s0;
    logic [SQ_W-1:0] sq_s0 [LANES];

    genvar i;
    generate
        for (i = 0; i < LANES; i++) begin : g_sq
            qn_square_lane u_sq (
                .aclk     (aclk),
                .ld       (ld[0]),
                .comp     (s_tdata[i*COMP_W +: COMP_W]),
                .comp_out (quad_s0[i]),
                .sq_out   (sq_s0[i])
            );
        end
    endgenerate

    // merge: sum of squares
    logic [SUM_W-1:0] sum_reg;
    quad_t            quad_s1_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            sum_reg     <= SUM_W'(sq_s0[0]) + SUM_W'(sq_s0[1])
                         + SUM_W'(sq_s0[2]) + SUM_W'(sq_s0[3]);
            quad_s1_reg <= quad_s0;
        end
    end

    logic [ROOT_W-1:0] root;
    quad_t             quad_rt;

    qn_isqrt u_sqrt (
        .aclk     (aclk),
        .ld       (ld[DIV_OFS-1:SQRT_OFS]),
        .sum_in   (sum_reg),
        .quad_in  (quad_s1_reg),
        .root_out (root),
        .quad_out (quad_rt)
    );

    logic [QW-1:0] quot [LANES];
    logic [LANES-1:0] neg;
    logic [LANES-1:0] zero;

    generate
        for (i = 0; i < LANES; i++) begin : g_div
            qn_div_lane #(.QW(QW)) u_div (
                .aclk (aclk),
                .ld   (ld[DIV_OFS+QW-1:DIV_OFS]),
                .comp (quad_rt[i]),
                .root (root),
                .quot (quot[i]),
                .neg  (neg[i]),
                .zero (zero[i])
            );
        end
    endgenerate

    // output register with saturation
    quad_t unit_next;
    quad_t unit_reg;
    logic  zero_reg;

    always_comb begin
        logic [31:0] qx;
        for (int k = 0; k < LANES; k++) begin
            qx = 32'(quot[k]);
            if (zero[0]) begin
                unit_next[k] = '0;
            end else if (neg[k]) begin
                unit_next[k] = (qx > NEG_LIMIT) ? comp_t'(-NEG_LIMIT) : comp_t'(-qx);
            end else begin
                unit_next[k] = (qx > POS_LIMIT) ? comp_t'(POS_LIMIT) : comp_t'(qx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[NS-1]) begin
            unit_reg <= unit_next;
            zero_reg <= zero[0];
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = unit_reg;
    assign m_tuser  = zero_reg;

endmodule

// ===== rtl/core/qn_square_lane.sv =====
module qn_square_lane
    import qn_pkg::*;
(
    input  logic            aclk,
    input  logic            ld,
    input  comp_t           comp,
    output comp_t           comp_out,
    output logic [SQ_W-1:0] sq_out
);

    logic signed [2*COMP_W-1:0] prod;
    comp_t                      comp_reg;
    logic [SQ_W-1:0]            sq_reg;

    assign prod = comp * comp;

    always_ff @(posedge aclk) begin
        if (ld) begin
            comp_reg <= comp;
            sq_reg   <= prod[SQ_W-1:0];
        end
    end

    assign comp_out = comp_reg;
    assign sq_out   = sq_reg;

endmodule

// ===== rtl/core/qn_isqrt.sv =====
module qn_isqrt
    import qn_pkg::*;
(
    input  logic              aclk,
    input  logic [ROOT_W-1:0] ld,
    input  logic [SUM_W-1:0]  sum_in,
    input  quad_t             quad_in,
    output logic [ROOT_W-1:0] root_out,
    output quad_t             quad_out
);

    localparam int SW  = 2 * ROOT_W;
    localparam int RMW = ROOT_W + 2;

    logic [SW-1:0]     s_reg    [ROOT_W];
    logic [RMW-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    quad_t             quad_reg [ROOT_W];

    logic [SW-1:0]     s_prev    [ROOT_W];
    logic [RMW-1:0]    rem_prev  [ROOT_W];
    logic [ROOT_W-1:0] root_prev [ROOT_W];
    quad_t             quad_prev [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_stage
            logic [RMW+1:0] rem_sh;
            logic [RMW+1:0] trial;
            logic           ge;

            if (j == 0) begin : g_first
                assign s_prev[j]    = SW'(sum_in);
                assign rem_prev[j]  = '0;
                assign root_prev[j] = '0;
                assign quad_prev[j] = quad_in;
            end else begin : g_rest
                assign s_prev[j]    = s_reg[j-1];
                assign rem_prev[j]  = rem_reg[j-1];
                assign root_prev[j] = root_reg[j-1];
                assign quad_prev[j] = quad_reg[j-1];
            end

            // two radicand bits per step
            assign rem_sh = {rem_prev[j], s_prev[j][SW-1:SW-2]};
            assign trial  = (RMW+2)'({root_prev[j], 2'b01});
            assign ge     = rem_sh >= trial;

            always_ff @(posedge aclk) begin
                if (ld[j]) begin
                    s_reg[j]    <= {s_prev[j][SW-3:0], 2'b00};
                    rem_reg[j]  <= ge ? RMW'(rem_sh - trial) : rem_sh[RMW-1:0];
                    root_reg[j] <= {root_prev[j][ROOT_W-2:0], ge};
                    quad_reg[j] <= quad_prev[j];
                end
            end
        end
    endgenerate

    assign root_out = root_reg[ROOT_W-1];
    assign quad_out = quad_reg[ROOT_W-1];

endmodule

// ===== rtl/core/qn_div_lane.sv =====
module qn_div_lane
    import qn_pkg::*;
#(
    parameter int QW = QN_FRAC_BITS + 1
) (
    input  logic              aclk,
    input  logic [QW-1:0]     ld,
    input  comp_t             comp,
    input  logic [ROOT_W-1:0] root,
    output logic [QW-1:0]     quot,
    output logic              neg,
    output logic              zero
);

    localparam int RW = ROOT_W;

    logic [RW-1:0] mag;

    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [RW-1:0] m_reg    [QW];
    logic          neg_reg  [QW];
    logic          zero_reg [QW];

    logic [RW-1:0] rem_prev  [QW];
    logic [QW-1:0] q_prev    [QW];
    logic [RW-1:0] m_prev    [QW];
    logic          neg_prev  [QW];
    logic          zero_prev [QW];
    logic          nb_prev   [QW];

    assign mag = comp[COMP_W-1] ? RW'(-$signed({comp[COMP_W-1], comp}))
                                : RW'({1'b0, comp});

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [RW:0] rem_sh;
            logic        ge;

            if (j == 0) begin : g_first
                // numerator is mag << frac; its low quotient-width bits are mag[0] then zeros
                assign rem_prev[j]  = mag >> 1;
                assign nb_prev[j]   = mag[0];
                assign q_prev[j]    = '0;
                assign m_prev[j]    = root;
                assign neg_prev[j]  = comp[COMP_W-1];
                assign zero_prev[j] = (root == '0);
            end else begin : g_rest
                assign rem_prev[j]  = rem_reg[j-1];
                assign nb_prev[j]   = 1'b0;
                assign q_prev[j]    = q_reg[j-1];
                assign m_prev[j]    = m_reg[j-1];
                assign neg_prev[j]  = neg_reg[j-1];
                assign zero_prev[j] = zero_reg[j-1];
            end

            assign rem_sh = {rem_prev[j], nb_prev[j]};
            assign ge     = rem_sh >= {1'b0, m_prev[j]};

            always_ff @(posedge aclk) begin
                if (ld[j]) begin
                    rem_reg[j]  <= ge ? RW'(rem_sh - {1'b0, m_prev[j]}) : rem_sh[RW-1:0];
                    q_reg[j]    <= {q_prev[j][QW-2:0], ge};
                    m_reg[j]    <= m_prev[j];
                    neg_reg[j]  <= neg_prev[j];
                    zero_reg[j] <= zero_prev[j];
                end
            end
        end
    endgenerate

    assign quot = q_reg[QW-1];
    assign neg  = neg_reg[QW-1];
    assign zero = zero_reg[QW-1];

endmodule

// ===== rtl/core/qn_checker.sv =====
`include "quaternion_normalizer_defines.svh"

module qn_checker
    import qn_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [4*COMP_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [4*COMP_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    `QN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
    `QN_ASSERT_NOW(a_zero_data, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0, "zero flag with nonzero data")
    `QN_ASSERT_NOW(a_unit_nonzero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata != '0, "unit result is all zero")
    `QN_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid straight after reset")

endmodule

bind quaternion_normalizer qn_checker u_qn_checker (.*);
